>>> rtl/aapr_pkg.sv
package aapr_pkg;

  localparam int CW = 34;
  localparam int ATAN_N = 24;

  // CORDIC gain compensation, Q2.30
  localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic signed [CW-1:0] ATAN_TAB [ATAN_N] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10680862,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81
  };

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] angle;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
  } aapr_in_t;

  typedef struct packed {
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;
    logic               saturated;
  } aapr_out_t;

  // what one CORDIC cell hands to the next
  typedef struct packed {
    logic              valid;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    aapr_in_t          item;
  } aapr_stage_t;

endpackage

>>> rtl/aapr_cell.sv
module aapr_cell #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  aapr_pkg::aapr_stage_t prev,
  output aapr_pkg::aapr_stage_t stage_r
);
  import aapr_pkg::*;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  aapr_stage_t          stage_nxt;

  assign dx = prev.y >>> STEP;
  assign dy = prev.x >>> STEP;

  always_comb begin
    stage_nxt = prev;
    if (prev.z >= 0) begin
      stage_nxt.x = prev.x - dx;
      stage_nxt.y = prev.y + dy;
      stage_nxt.z = prev.z - ATAN_TAB[STEP];
    end else begin
      stage_nxt.x = prev.x + dx;
      stage_nxt.y = prev.y - dy;
      stage_nxt.z = prev.z + ATAN_TAB[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.x    <= stage_nxt.x;
    stage_r.y    <= stage_nxt.y;
    stage_r.z    <= stage_nxt.z;
    stage_r.item <= stage_nxt.item;
  end

endmodule

>>> rtl/aapr_quat.sv
module aapr_quat #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  aapr_pkg::aapr_stage_t cell_in,
  output logic                  res_valid,
  output aapr_pkg::aapr_out_t   res_data
);
  import aapr_pkg::*;

  localparam int RW  = FRAC_BITS + 4;
  localparam int AVW = 16 + CW;
  localparam int M1W = RW + 32;
  localparam int TW  = M1W + 2 - FRAC_BITS;
  localparam int THW = TW - 16;
  localparam int PHW = THW + RW;
  localparam int PLW = 17 + RW;
  localparam int M2W = TW + RW;
  localparam int SW  = M2W + 2 - FRAC_BITS;
  localparam int STAGES = 7;

  localparam logic signed [CW-1:0]    WHALF = CW'(1) << (29 - FRAC_BITS);
  localparam logic signed [AVW-1:0]   VHALF = AVW'(1) << (43 - FRAC_BITS);
  localparam logic signed [M1W+1:0]   THALF = (M1W + 2)'(1) << (FRAC_BITS - 1);
  localparam logic signed [M2W+1:0]   SHALF = (M2W + 2)'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0]    SMAX  = SW'(2147483647);
  localparam logic signed [SW-1:0]    SMIN  = -SMAX - SW'(1);

  // operand pairs of the second product: t index and r index (w=0, v1..v3)
  localparam int TI [12] = '{0, 1, 2, 3, 0, 2, 3, 1, 0, 3, 1, 2};
  localparam int RI [12] = '{1, 0, 3, 2, 2, 0, 1, 3, 3, 0, 2, 1};

  logic [STAGES-1:0] vld_r;

  // stage 1: w rounded, axis * sin products
  logic signed [CW-1:0]  w_full;
  logic signed [RW-1:0]  w1_r;
  logic signed [AVW-1:0] av_r [3];
  logic signed [31:0]    p1_r [3];

  // stage 2: R components
  logic signed [AVW-1:0] v_full [3];
  logic signed [RW-1:0]  r2_r [4];
  logic signed [31:0]    p2_r [3];

  // stage 3: R * P products
  logic signed [M1W-1:0] m1_r [12];
  logic signed [RW-1:0]  r3_r [4];

  // stage 4: t = R * P
  logic signed [M1W+1:0] e1 [12];
  logic signed [M1W+1:0] ts [4];
  logic signed [M1W+1:0] tr [4];
  logic signed [TW-1:0]  t4_r [4];
  logic signed [RW-1:0]  r4_r [4];

  // stage 5: partial products of t * conj(R)
  logic signed [THW-1:0] th [12];
  logic signed [16:0]    tl [12];
  logic signed [PHW-1:0] ph_r [12];
  logic signed [PLW-1:0] pl_r [12];

  // stage 6: full products
  logic signed [M2W-1:0] m2_r [12];

  // stage 7: sums, rounding, clamp
  logic signed [M2W+1:0] e2 [12];
  logic signed [M2W+1:0] ss [3];
  logic signed [M2W+1:0] sr [3];
  logic signed [SW-1:0]  sv [3];
  logic signed [31:0]    cl [3];
  logic [2:0]            sat;

  assign w_full = (cell_in.x + WHALF) >>> (30 - FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[STAGES-2:0], cell_in.valid};
    end
  end

  always_ff @(posedge clk) begin
    w1_r    <= w_full[RW-1:0];
    av_r[0] <= cell_in.item.axis_x * cell_in.y;
    av_r[1] <= cell_in.item.axis_y * cell_in.y;
    av_r[2] <= cell_in.item.axis_z * cell_in.y;
    p1_r[0] <= cell_in.item.point_x;
    p1_r[1] <= cell_in.item.point_y;
    p1_r[2] <= cell_in.item.point_z;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v_full[k] = (av_r[k] + VHALF) >>> (44 - FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    r2_r[0] <= w1_r;
    for (int k = 0; k < 3; k++) begin
      r2_r[k+1] <= v_full[k][RW-1:0];
      p2_r[k]   <= p1_r[k];
    end
  end

  // products order: v1px v2py v3pz wpx v2pz v3py wpy v3px v1pz wpz v1py v2px
  always_ff @(posedge clk) begin
    m1_r[0]  <= r2_r[1] * p2_r[0];
    m1_r[1]  <= r2_r[2] * p2_r[1];
    m1_r[2]  <= r2_r[3] * p2_r[2];
    m1_r[3]  <= r2_r[0] * p2_r[0];
    m1_r[4]  <= r2_r[2] * p2_r[2];
    m1_r[5]  <= r2_r[3] * p2_r[1];
    m1_r[6]  <= r2_r[0] * p2_r[1];
    m1_r[7]  <= r2_r[3] * p2_r[0];
    m1_r[8]  <= r2_r[1] * p2_r[2];
    m1_r[9]  <= r2_r[0] * p2_r[2];
    m1_r[10] <= r2_r[1] * p2_r[1];
    m1_r[11] <= r2_r[2] * p2_r[0];
    r3_r     <= r2_r;
  end

  always_comb begin
    for (int i = 0; i < 12; i++) begin
      e1[i] = (M1W + 2)'(m1_r[i]);
    end
    ts[0] = -(e1[0] + e1[1] + e1[2]);
    ts[1] = e1[3] + e1[4] - e1[5];
    ts[2] = e1[6] + e1[7] - e1[8];
    ts[3] = e1[9] + e1[10] - e1[11];
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      tr[i] = (ts[i] + THALF) >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      t4_r[i] <= tr[i][TW-1:0];
    end
    r4_r <= r3_r;
  end

  always_comb begin
    for (int k = 0; k < 12; k++) begin
      th[k] = t4_r[TI[k]][TW-1:16];
      tl[k] = $signed({1'b0, t4_r[TI[k]][15:0]});
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 12; k++) begin
      ph_r[k] <= th[k] * r4_r[RI[k]];
      pl_r[k] <= tl[k] * r4_r[RI[k]];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 12; k++) begin
      m2_r[k] <= (M2W'(ph_r[k]) <<< 16) + M2W'(pl_r[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 12; k++) begin
      e2[k] = (M2W + 2)'(m2_r[k]);
    end
    for (int j = 0; j < 3; j++) begin
      ss[j] = e2[4*j+1] - e2[4*j] - e2[4*j+2] + e2[4*j+3];
      sr[j] = (ss[j] + SHALF) >>> FRAC_BITS;
      sv[j] = sr[j][SW-1:0];
      if (sv[j] > SMAX) begin
        cl[j]  = 32'sh7FFF_FFFF;
        sat[j] = 1'b1;
      end else if (sv[j] < SMIN) begin
        cl[j]  = 32'sh8000_0000;
        sat[j] = 1'b1;
      end else begin
        cl[j]  = sv[j][31:0];
        sat[j] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_data.rotated_x <= cl[0];
    res_data.rotated_y <= cl[1];
    res_data.rotated_z <= cl[2];
    res_data.saturated <= |sat;
  end

  assign res_valid = vld_r[STAGES-1];

endmodule

>>> rtl/axis_angle_point_rotator.sv
// Rotates a Q15.16 point about a Q1.14 axis (used as given, not normalized)
// by a 16-bit binary angle through R*P*conj(R), R = (cos(a/2), axis*sin(a/2)).
// One item is accepted per clock while in_ready is high; each item passes
// through the row of CORDIC cells (one per iteration) and the seven stages of
// the quaternion products, then the output queue and output register.
// Results that leave the 32-bit range clamp and raise saturated.
module axis_angle_point_rotator #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  aapr_pkg::aapr_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output aapr_pkg::aapr_out_t  out_data
);
  import aapr_pkg::*;

  localparam int LAT = CORDIC_STEPS + 7;
  localparam int AW  = $clog2(LAT + 1);
  localparam int FD  = 1 << AW;
  localparam int OW  = AW + 2;

  aapr_stage_t chain [CORDIC_STEPS+1];
  logic        res_valid;
  aapr_out_t   res_data;

  aapr_out_t   fifo_mem [FD];
  logic [AW:0] wr_ptr_r, rd_ptr_r;
  logic [OW-1:0] occ_r, occ_nxt;
  logic        in_acc, out_acc, fifo_empty, load;
  logic        out_valid_r;

  assign in_ready = (occ_r < OW'(FD));
  assign in_acc   = in_valid & in_ready;
  assign out_acc  = out_valid_r & out_ready;

  always_comb begin
    chain[0].valid = in_acc;
    chain[0].x     = CORDIC_K;
    chain[0].y     = '0;
    chain[0].z     = CW'(in_data.angle) <<< 15;
    chain[0].item  = in_data;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    aapr_cell #(.STEP(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .prev    (chain[i]),
      .stage_r (chain[i+1])
    );
  end

  aapr_quat #(.FRAC_BITS(FRAC_BITS)) u_quat (
    .clk       (clk),
    .rst_n     (rst_n),
    .cell_in   (chain[CORDIC_STEPS]),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  assign fifo_empty = (wr_ptr_r == rd_ptr_r);
  assign load       = !fifo_empty && (!out_valid_r || out_ready);

  always_comb begin
    occ_nxt = occ_r;
    if (in_acc && !out_acc) begin
      occ_nxt = occ_r + OW'(1);
    end else if (!in_acc && out_acc) begin
      occ_nxt = occ_r - OW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (res_valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (load) begin
        rd_ptr_r    <= rd_ptr_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      fifo_mem[wr_ptr_r[AW-1:0]] <= res_data;
    end
    if (load) begin
      out_data <= fifo_mem[rd_ptr_r[AW-1:0]];
    end
  end

  assign out_valid = out_valid_r;

endmodule
